[hw/rtl/dtwv_pkg.sv]
// ----------------------------------------------------------------------------
// dtwv_pkg
// Shared constants, types and arithmetic helpers for the direction to wave
// vector pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dtwv_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int TRIG_STAGES_DEF     = 16;

  // pipeline sections around the cordic
  localparam int FRONT_STAGES = 3;
  localparam int POST_STAGES  = 4;

  // cordic datapath width, signed q2.30 with headroom
  localparam int CORDIC_W = 34;

  localparam logic signed [CORDIC_W-1:0] CORDIC_START = CORDIC_W'(652032874);
  // round(pi/180 * 2^32)
  localparam logic [26:0] DEG_RAD_Q32      = 27'd74961321;
  localparam logic [31:0] WAVE_SCALE_RESET = 32'd253873;
  localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] cos_v;
    logic signed [CORDIC_W-1:0] sin_v;
  } trig_t;

  // arctangent of 2^-i in q2.30
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] t;
    case (i)
      0: t = 32'd843314857;
      1: t = 32'd497837829;
      2: t = 32'd263043837;
      3: t = 32'd133525159;
      4: t = 32'd67021687;
      5: t = 32'd33543516;
      6: t = 32'd16775851;
      7: t = 32'd8388437;
      8: t = 32'd4194283;
      9: t = 32'd2097149;
      default: t = (i <= 30) ? (32'd1 << (30 - i)) : 32'd0;
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [CORDIC_W-1:0] v);
    logic signed [31:0] r;
    if (v > CORDIC_W'(ONE_Q30)) begin
      r = ONE_Q30;
    end else if (v < -CORDIC_W'(ONE_Q30)) begin
      r = -ONE_Q30;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // floor((p + 2^29) / 2^30)
  function automatic logic signed [65:0] round_q30(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = p + 66'sh2000_0000;
    return s >>> 30;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/dtwv_front.sv]
// ----------------------------------------------------------------------------
// dtwv_front
// Angle clamp, azimuth quadrant fold and degree to q2.30 radian conversion,
// three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dtwv_front #(
  parameter int ANGLE_FRAC_BITS = dtwv_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic [dtwv_pkg::FRONT_STAGES-1:0]     en,
  input  wire logic [16:0]                           azimuth_deg,
  input  wire logic [14:0]                           zenith_deg,
  output logic signed [dtwv_pkg::CORDIC_W-1:0]       az_rad,
  output logic signed [dtwv_pkg::CORDIC_W-1:0]       za_rad,
  output logic                                       flip
);

  localparam int F  = ANGLE_FRAC_BITS;
  localparam int IW = (F + 10 > 18) ? F + 10 : 18;
  localparam int MW = F + 7;
  localparam int PW = MW + 27;
  localparam int CW = dtwv_pkg::CORDIC_W;

  localparam logic signed [IW-1:0] FULL    = IW'(360 * (2 ** F));
  localparam logic signed [IW-1:0] HALF    = IW'(180 * (2 ** F));
  localparam logic signed [IW-1:0] QUARTER = IW'(90 * (2 ** F));
  localparam logic [PW:0]          RND     = (PW + 1)'(1) << (F + 1);

  logic signed [IW-1:0] az_ext, az_clip, az_wrap, az_fold, za_ext;
  logic                 fold;
  logic [MW-1:0]        az_mag, za_mag;

  always_comb begin
    az_ext = $signed(IW'({1'b0, azimuth_deg}));
    za_ext = $signed(IW'({1'b0, zenith_deg}));
    az_clip = (az_ext >= FULL) ? FULL - IW'(1) : az_ext;
    az_wrap = (az_clip >= HALF) ? az_clip - FULL : az_clip;
    fold = 1'b0;
    az_fold = az_wrap;
    if (az_wrap > QUARTER) begin
      az_fold = az_wrap - HALF;
      fold = 1'b1;
    end else if (az_wrap < -QUARTER) begin
      az_fold = az_wrap + HALF;
      fold = 1'b1;
    end
    az_mag = az_fold[IW-1] ? MW'(-az_fold) : MW'(az_fold);
    za_mag = (za_ext > QUARTER) ? MW'(QUARTER) : MW'(za_ext);
  end

  // stage 1: folded magnitudes
  logic [MW-1:0] s1_az_mag, s1_za_mag;
  logic          s1_az_neg, s1_flip;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_az_mag <= az_mag;
      s1_za_mag <= za_mag;
      s1_az_neg <= az_fold[IW-1];
      s1_flip   <= fold;
    end
  end

  // stage 2: scale by pi/180
  logic [PW-1:0] s2_az_prod, s2_za_prod;
  logic          s2_az_neg, s2_flip;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_az_prod <= PW'(s1_az_mag) * PW'(dtwv_pkg::DEG_RAD_Q32);
      s2_za_prod <= PW'(s1_za_mag) * PW'(dtwv_pkg::DEG_RAD_Q32);
      s2_az_neg  <= s1_az_neg;
      s2_flip    <= s1_flip;
    end
  end

  // stage 3: round to q2.30 and restore sign
  logic [PW:0]          az_sum, za_sum;
  logic signed [CW-1:0] az_abs, za_abs;

  always_comb begin
    az_sum = {1'b0, s2_az_prod} + RND;
    za_sum = {1'b0, s2_za_prod} + RND;
    az_abs = $signed(CW'(az_sum[F+2 +: 31]));
    za_abs = $signed(CW'(za_sum[F+2 +: 31]));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      az_rad <= s2_az_neg ? -az_abs : az_abs;
      za_rad <= za_abs;
      flip   <= s2_flip;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/dtwv_cordic.sv]
// ----------------------------------------------------------------------------
// dtwv_cordic
// Rotation-mode cordic, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dtwv_cordic #(
  parameter int TRIG_STAGES = dtwv_pkg::TRIG_STAGES_DEF
) (
  input  wire logic                                   clk,
  input  wire logic [TRIG_STAGES-1:0]                 en,
  input  wire logic signed [dtwv_pkg::CORDIC_W-1:0]   angle,
  output dtwv_pkg::trig_t                             trig
);

  localparam int CW = dtwv_pkg::CORDIC_W;

  logic signed [CW-1:0] x_r [TRIG_STAGES];
  logic signed [CW-1:0] y_r [TRIG_STAGES];
  logic signed [CW-1:0] z_r [TRIG_STAGES];

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
    logic signed [CW-1:0] xp, yp, zp, dx, dy, tv;

    if (i == 0) begin : g_first
      assign xp = dtwv_pkg::CORDIC_START;
      assign yp = '0;
      assign zp = angle;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end

    assign dx = yp >>> i;
    assign dy = xp >>> i;
    assign tv = $signed(CW'(dtwv_pkg::atan_q30(i)));

    always_ff @(posedge clk) begin
      if (en[i]) begin
        if (!zp[CW-1]) begin
          x_r[i] <= xp - dx;
          y_r[i] <= yp + dy;
          z_r[i] <= zp - tv;
        end else begin
          x_r[i] <= xp + dx;
          y_r[i] <= yp - dy;
          z_r[i] <= zp + tv;
        end
      end
    end
  end

  assign trig.cos_v = x_r[TRIG_STAGES-1];
  assign trig.sin_v = y_r[TRIG_STAGES-1];

endmodule

`default_nettype wire

[hw/rtl/dtwv_scale.sv]
// ----------------------------------------------------------------------------
// dtwv_scale
// Clamps the trig results and scales them by the wave scale into the three
// saturated q16.16 wave vector components, four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dtwv_scale (
  input  wire logic                               clk,
  input  wire logic [dtwv_pkg::POST_STAGES-1:0]   en,
  input  wire logic [31:0]                        wave_scale,
  input  wire dtwv_pkg::trig_t                    az_trig,
  input  wire dtwv_pkg::trig_t                    za_trig,
  input  wire logic                               flip,
  output logic signed [31:0]                      wave_x,
  output logic signed [31:0]                      wave_y,
  output logic signed [31:0]                      wave_z
);

  logic signed [31:0] saz_c, caz_c, sza_c, cza_c;

  always_comb begin
    saz_c = dtwv_pkg::clamp_unit(az_trig.sin_v);
    caz_c = dtwv_pkg::clamp_unit(az_trig.cos_v);
    sza_c = dtwv_pkg::clamp_unit(za_trig.sin_v);
    cza_c = dtwv_pkg::clamp_unit(za_trig.cos_v);
  end

  // p0: scale times zenith sine and cosine
  logic signed [64:0] p0_as, p0_z;
  logic signed [31:0] p0_saz, p0_caz;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p0_as  <= $signed({1'b0, wave_scale}) * sza_c;
      p0_z   <= $signed({1'b0, wave_scale}) * cza_c;
      p0_saz <= flip ? -saz_c : saz_c;
      p0_caz <= flip ? -caz_c : caz_c;
    end
  end

  // p1: round horizontal magnitude, finish vertical component
  logic signed [65:0] as_rnd;
  logic signed [33:0] p1_s;
  logic signed [31:0] p1_z, p1_saz, p1_caz;

  assign as_rnd = dtwv_pkg::round_q30(66'(p0_as));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p1_s   <= as_rnd[33:0];
      p1_z   <= dtwv_pkg::sat32(dtwv_pkg::round_q30(66'(p0_z)));
      p1_saz <= p0_saz;
      p1_caz <= p0_caz;
    end
  end

  // p2: horizontal products
  logic signed [65:0] p2_x, p2_y;
  logic signed [31:0] p2_z;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p2_x <= p1_s * p1_saz;
      p2_y <= p1_s * p1_caz;
      p2_z <= p1_z;
    end
  end

  // p3: round and saturate into the output register
  always_ff @(posedge clk) begin
    if (en[3]) begin
      wave_x <= dtwv_pkg::sat32(dtwv_pkg::round_q30(p2_x));
      wave_y <= dtwv_pkg::sat32(dtwv_pkg::round_q30(p2_y));
      wave_z <= p2_z;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/direction_to_wave_vector.sv]
// ----------------------------------------------------------------------------
// direction_to_wave_vector
// Look direction (azimuth, zenith in fixed-point degrees) to the 3d
// wavenumber vector scaled by a configurable 2*pi/lambda.
// ----------------------------------------------------------------------------
// throughput: one request per cycle while m_tready keeps the output moving; every stage holds
//   one item and advances whenever the stage after it is empty or moving, so bubbles collapse
// reset: clears all stage valid bits and loads wave_scale with 253873
// ----------------------------------------------------------------------------
`default_nettype none

module direction_to_wave_vector #(
  parameter int ANGLE_FRAC_BITS = dtwv_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int TRIG_STAGES     = dtwv_pkg::TRIG_STAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // wave scale register write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,     // wave_scale, unsigned q16.16
  // look direction requests
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,      // azimuth_deg [16:0], zenith_deg [31:17]
  // wave vector results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata       // wave_x [31:0], wave_y [63:32], wave_z [95:64]
);

  localparam int FS = dtwv_pkg::FRONT_STAGES;
  localparam int PS = dtwv_pkg::POST_STAGES;
  localparam int NS = FS + TRIG_STAGES + PS;

  // --------------------------------------------------------------------------
  // wave scale register, always writable
  // --------------------------------------------------------------------------
  logic [31:0] wave_scale;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_scale <= dtwv_pkg::WAVE_SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wave_scale <= cfg_data;
    end
  end

  // --------------------------------------------------------------------------
  // stage flow control: a stage loads when it is empty or its successor loads;
  // the last stage is the output register
  // --------------------------------------------------------------------------
  logic [NS-1:0] valid;
  logic [NS-1:0] en;

  assign en[NS-1] = !valid[NS-1] || m_tready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !valid[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = valid[NS-1];

  // --------------------------------------------------------------------------
  // front end: clamp, fold azimuth into [-90, 90] degrees, convert to radians
  // --------------------------------------------------------------------------
  logic signed [dtwv_pkg::CORDIC_W-1:0] az_rad, za_rad;
  logic                                 front_flip;

  dtwv_front #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .en          (en[FS-1:0]),
    .azimuth_deg (s_tdata[16:0]),
    .zenith_deg  (s_tdata[31:17]),
    .az_rad      (az_rad),
    .za_rad      (za_rad),
    .flip        (front_flip)
  );

  // --------------------------------------------------------------------------
  // two cordic lanes in lock step, one for each angle
  // --------------------------------------------------------------------------
  dtwv_pkg::trig_t az_trig, za_trig;

  dtwv_cordic #(
    .TRIG_STAGES (TRIG_STAGES)
  ) u_cordic_az (
    .clk   (clk),
    .en    (en[FS +: TRIG_STAGES]),
    .angle (az_rad),
    .trig  (az_trig)
  );

  dtwv_cordic #(
    .TRIG_STAGES (TRIG_STAGES)
  ) u_cordic_za (
    .clk   (clk),
    .en    (en[FS +: TRIG_STAGES]),
    .angle (za_rad),
    .trig  (za_trig)
  );

  // the fold flag rides alongside the cordic stages; a folded azimuth has
  // both its sine and cosine negated afterwards
  logic flip_d [TRIG_STAGES];

  for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_flip
    always_ff @(posedge clk) begin
      if (en[FS+i]) begin
        flip_d[i] <= (i == 0) ? front_flip : flip_d[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // back end: clamp, scale by wave_scale, round and saturate
  // --------------------------------------------------------------------------
  logic signed [31:0] wave_x, wave_y, wave_z;

  dtwv_scale u_scale (
    .clk        (clk),
    .en         (en[FS+TRIG_STAGES +: PS]),
    .wave_scale (wave_scale),
    .az_trig    (az_trig),
    .za_trig    (za_trig),
    .flip       (flip_d[TRIG_STAGES-1]),
    .wave_x     (wave_x),
    .wave_y     (wave_y),
    .wave_z     (wave_z)
  );

  assign m_tdata = {wave_z, wave_y, wave_x};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // an empty output register always lets the whole pipeline move
  a_free_output_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register is empty");

  // a full pipeline with a stalled output takes no request
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    ((&valid) && !m_tready) |-> !s_tready)
    else $error("request taken into a full stalled pipeline");

  // an accepted request occupies the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> valid[0])
    else $error("accepted request lost at the first stage");

endmodule

`default_nettype wire

[dv/dtwv_checker.sv]
// ----------------------------------------------------------------------------
// dtwv_checker
// Watches the wave scale, look direction and wave vector channels, predicts
// every wave vector from the accepted direction and compares it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module dtwv_checker #(
  parameter int ANGLE_FRAC_BITS = dtwv_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int TRIG_STAGES     = dtwv_pkg::TRIG_STAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [31:0] s_tdata,   // azimuth_deg [16:0], zenith_deg [31:17]
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [95:0] m_tdata,   // wave_x [31:0], wave_y [63:32], wave_z [95:64]
  output int               mismatches,
  output int               outstanding,
  output int               vectors_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [31:0] wave_z;
    logic signed [31:0] wave_y;
    logic signed [31:0] wave_x;
  } wave_vec_t;

  typedef struct packed {
    logic signed [63:0] cos_q30;
    logic signed [63:0] sin_q30;
  } rot_t;

  logic [31:0] scale_q16;
  wave_vec_t   pending_vectors[$];

  function automatic longint atan_step(input int i);
    longint t;
    case (i)
      0: t = 843314857;
      1: t = 497837829;
      2: t = 263043837;
      3: t = 133525159;
      4: t = 67021687;
      5: t = 33543516;
      6: t = 16775851;
      7: t = 8388437;
      8: t = 4194283;
      9: t = 2097149;
      default: t = (i <= 30) ? (longint'(1) << (30 - i)) : 0;
    endcase
    return t;
  endfunction

  function automatic longint limit_unit(input longint v);
    longint one;
    one = longint'(1) << 30;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // rounded q30 product, arithmetic shift gives the floor
  function automatic longint q30_product(input longint a, input longint t);
    return (a * t + (longint'(1) << 29)) >>> 30;
  endfunction

  function automatic longint degrees_to_q30(input longint d);
    longint mag;
    longint r;
    mag = (d < 0) ? -d : d;
    r = (mag * longint'(dtwv_pkg::DEG_RAD_Q32) + (longint'(1) << (ANGLE_FRAC_BITS + 1)))
        >>> (ANGLE_FRAC_BITS + 2);
    return (d < 0) ? -r : r;
  endfunction

  function automatic rot_t rotate_unit(input longint angle);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint t;
    rot_t   r;
    x = 652032874;
    y = 0;
    z = angle;
    for (int i = 0; i < TRIG_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      t  = atan_step(i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - t;
      end else begin
        x = x + dx; y = y - dy; z = z + t;
      end
    end
    r.cos_q30 = limit_unit(x);
    r.sin_q30 = limit_unit(y);
    return r;
  endfunction

  function automatic wave_vec_t predict_wave(input logic [16:0] az_in,
                                             input logic [14:0] za_in,
                                             input logic [31:0] scale);
    longint    full;
    longint    half;
    longint    quarter;
    longint    az;
    longint    za;
    longint    a;
    longint    a_sin;
    logic      flip;
    rot_t      az_rot;
    rot_t      za_rot;
    wave_vec_t w;
    full    = longint'(360) << ANGLE_FRAC_BITS;
    half    = longint'(180) << ANGLE_FRAC_BITS;
    quarter = longint'(90) << ANGLE_FRAC_BITS;
    az      = longint'(az_in);
    za      = longint'(za_in);
    flip    = 1'b0;
    if (az >= full) az = full - 1;
    if (za > quarter) za = quarter;
    // fold azimuth into [-90, 90] and remember to negate sin and cos
    if (az >= half) az = az - full;
    if (az > quarter) begin
      az = az - half; flip = 1'b1;
    end else if (az < -quarter) begin
      az = az + half; flip = 1'b1;
    end
    az_rot = rotate_unit(degrees_to_q30(az));
    if (flip) begin
      az_rot.cos_q30 = -az_rot.cos_q30;
      az_rot.sin_q30 = -az_rot.sin_q30;
    end
    za_rot   = rotate_unit(degrees_to_q30(za));
    a        = longint'(scale);
    a_sin    = q30_product(a, za_rot.sin_q30);
    w.wave_x = clip32(q30_product(a_sin, az_rot.sin_q30));
    w.wave_y = clip32(q30_product(a_sin, az_rot.cos_q30));
    w.wave_z = clip32(q30_product(a, za_rot.cos_q30));
    return w;
  endfunction

  task automatic report_field(input string field, input logic signed [31:0] want,
                              input logic signed [31:0] got);
    if (want !== got) begin
      if (mismatches < MAX_REPORTS) begin
        $display("[%0t] mismatch on %s of vector %0d: expected %0d got %0d",
                 $time, field, vectors_checked, want, got);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    wave_vec_t want;
    wave_vec_t got;
    if (rst) begin
      scale_q16 = dtwv_pkg::WAVE_SCALE_RESET;
      pending_vectors.delete();
      mismatches      = 0;
      vectors_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scale_q16 = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        pending_vectors.push_back(predict_wave(s_tdata[16:0], s_tdata[31:17], scale_q16));
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_vectors.size() == 0) begin
          if (mismatches < MAX_REPORTS) begin
            $display("[%0t] wave vector with no request outstanding: x %0d y %0d z %0d",
                     $time, got.wave_x, got.wave_y, got.wave_z);
          end
          mismatches++;
        end else begin
          want = pending_vectors.pop_front();
          report_field("wave_x", want.wave_x, got.wave_x);
          report_field("wave_y", want.wave_y, got.wave_y);
          report_field("wave_z", want.wave_z, got.wave_z);
        end
        vectors_checked++;
      end
    end
    outstanding = pending_vectors.size();
  end

endmodule

`default_nettype wire

[dv/tb_direction_to_wave_vector.sv]
// ----------------------------------------------------------------------------
// tb_direction_to_wave_vector
// Drives look directions through the wave vector pipeline under several wave
// scales, with random gaps and stalls and one long output hold-off; the
// checker predicts and compares every wave vector.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_direction_to_wave_vector;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_FRAC_BITS = dtwv_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int TRIG_STAGES     = dtwv_pkg::TRIG_STAGES_DEF;

  // angle landmarks in q9.8 (azimuth) and q7.8 (zenith) degrees
  localparam logic [16:0] AZ_90       = 17'd23040;
  localparam logic [16:0] AZ_180      = 17'd46080;
  localparam logic [16:0] AZ_270      = 17'd69120;
  localparam logic [16:0] AZ_MAX      = 17'd92159;
  localparam logic [16:0] AZ_360      = 17'd92160;
  localparam logic [14:0] ZA_90       = 15'd23040;

  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NO_IDLE_PHASE   = 3;
  localparam int HOLD_PHASE      = 4;
  localparam int HOLD_CYCLES     = 400;
  localparam int PIPE_LATENCY    = TRIG_STAGES + 7;
  localparam int DRAIN_CYCLES    = 2 * PIPE_LATENCY;
  // slowest legal stretch is the hold-off plus a long gap, well under this
  localparam int WATCHDOG_LIMIT  = 5000;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;      // wave_scale, unsigned q16.16
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;       // azimuth_deg [16:0], zenith_deg [31:17]
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;       // wave_x [31:0], wave_y [63:32], wave_z [95:64]

  int mismatches;
  int outstanding;
  int vectors_checked;

  // stimulus mode flags shared with the sink process
  logic no_idle;
  logic hold_req;

  int directions_sent;
  int scales_used;

  direction_to_wave_vector #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .TRIG_STAGES    (TRIG_STAGES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  dtwv_checker #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .TRIG_STAGES    (TRIG_STAGES)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .vectors_checked(vectors_checked)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one look direction request; starts and ends just after a falling edge
  task automatic send_direction(input logic [16:0] az, input logic [14:0] za);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {za, az};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    directions_sent++;
    @(negedge clk);
  endtask

  // wave scale write, only called with the pipeline empty
  task automatic write_scale(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scales_used++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
  endtask

  // random direction: mostly in range, some near the fold points,
  // some over the full field width so clamping and every bit are hit
  task automatic send_random_direction();
    int          kind;
    logic [16:0] az;
    logic [14:0] za;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      az = 17'($urandom_range(0, 92159));
      za = 15'($urandom_range(0, 23040));
    end else if (kind < 88) begin
      az = 17'($urandom);
      za = 15'($urandom);
    end else begin
      case ($urandom_range(0, 4))
        0: az = AZ_90;
        1: az = AZ_180;
        2: az = AZ_270;
        3: az = AZ_MAX;
        default: az = 17'd0;
      endcase
      az = az + 17'($urandom_range(0, 4)) - 17'd2;
      za = ($urandom_range(0, 1) == 1) ? ZA_90 + 15'($urandom_range(0, 2)) - 15'd1
                                       : 15'($urandom_range(0, 3));
    end
    send_direction(az, za);
  endtask

  function automatic logic [31:0] scale_for_phase(input int p);
    case (p)
      1: return 32'hFFFF_FFFF;                   // saturates the outputs
      2: return 32'd0;
      3: return 32'($urandom);
      4: return 32'd1;
      5: return 32'h8000_0000;
      default: return 32'($urandom_range(0, 32'h0010_0000));
    endcase
  endfunction

  // sink: random stalls, no stalls in the no-idle phase, one long hold-off
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      int stall;
      stall = idle_len();
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (stall == 0) begin
        m_tready <= 1'b1;
        @(negedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // watchdog: cycles in a row with no request accepted on any channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog expired with %0d wave vectors outstanding", outstanding);
    $display("FAIL direction_to_wave_vector");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    s_tvalid        = 1'b0;
    s_tdata         = '0;
    no_idle         = 1'b0;
    hold_req        = 1'b0;
    directions_sent = 0;
    scales_used     = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: field extremes, fold boundaries and clamping, reset scale
    send_direction(17'd0, 15'd0);
    send_direction(17'd0, ZA_90);
    send_direction(AZ_90, ZA_90);
    send_direction(AZ_90 + 17'd1, ZA_90);      // just past 90, folds
    send_direction(AZ_90 - 17'd1, 15'd11520);
    send_direction(AZ_180 - 17'd1, 15'd11520); // just under 180
    send_direction(AZ_180, 15'd11520);         // wraps to -180
    send_direction(AZ_270, 15'd5760);          // exactly -90, no fold
    send_direction(AZ_270 - 17'd1, 15'd5760);  // just past -90, folds
    send_direction(AZ_MAX, ZA_90);
    send_direction(AZ_360, ZA_90);             // azimuth clamps
    send_direction(17'h1FFFF, 15'h7FFF);       // both clamp, all ones
    send_direction(17'd11520, ZA_90 + 15'd1);  // zenith just over 90
    send_direction(17'd34560, ZA_90 - 15'd1);
    send_direction(17'd57600, 15'd1);
    send_direction(17'd80640, 15'd16384);
    send_direction(17'd65536, 15'd17280);
    send_direction(17'd1, 15'd23039);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        // stop offering before draining so the last request is not taken again
        s_tvalid <= 1'b0;
        wait_drained();
        write_scale(scale_for_phase(p));
      end
      no_idle = (p == NO_IDLE_PHASE);
      // long output hold-off while the source keeps offering directions
      if (p == HOLD_PHASE) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_random_direction();
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d look directions over %0d wave scale settings, %0d vectors checked",
             directions_sent, scales_used, vectors_checked);
    $display("covered fold points, clamping, saturation, stalls and a %0d cycle hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS direction_to_wave_vector");
    end else begin
      $display("%0d mismatches, %0d vectors outstanding", mismatches, outstanding);
      $display("FAIL direction_to_wave_vector");
    end
    $finish;
  end

endmodule

`default_nettype wire
